// ===== sv/arpc_pkg.sv =====
// Shared types and constants of the ARP cache and reply engine.
package arpc_pkg;

  // Received ARP opcodes (host order)
  localparam logic [15:0] OPC_REQUEST = 16'd1;
  localparam logic [15:0] OPC_REPLY   = 16'd2;

  // Opcodes of frames to send
  localparam logic [1:0] SEND_OPC_REQUEST = 2'd1;
  localparam logic [1:0] SEND_OPC_REPLY   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADOP = 2'd3;

  // Configuration register indexes
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        operation;
    logic [15:0] arp_opcode;
    logic [47:0] snd_hw_addr;
    logic [31:0] snd_ip_addr;
    logic [47:0] frame_source_mac;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] found_mac;
    logic        send_valid;
    logic [1:0]  send_opcode;
    logic [47:0] send_dest_mac;
    logic [47:0] send_target_mac;
    logic [31:0] send_target_ip;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture request, start table read at slot zero
    logic scan;  // compare current slot, advance
    logic emit;  // load result into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;  // incoming request walks the table
    logic hit;         // current slot matches the key
    logic last;        // current slot is the final one
    logic out_free;    // output register can take a result
  } dp_stat_t;

endpackage

// ===== sv/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/arpc_ctrl.sv =====
// Sequencing state machine: accept, table walk, result hand-off.
module arpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arpc_pkg::dp_stat_t  stat_i,
  output arpc_pkg::ctrl_cmd_t cmd_o
);
  import arpc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit || stat_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan = (state_q == ST_SCAN);
    cmd_o.emit = (state_q == ST_DONE) && stat_i.out_free;
  end

endmodule

// ===== sv/arpc_dp.sv =====
// Datapath: request register, slot tables, scan counter, result register.
module arpc_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arpc_pkg::in_item_t  in_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  arpc_pkg::ctrl_cmd_t cmd_i,
  output arpc_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output arpc_pkg::out_item_t out_data_o
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  in_item_t         item_q;
  logic [IW-1:0]    idx_q, rd_addr;
  logic             hit_q;
  logic [47:0]      fmac_q;
  logic [TABLE_ENTRIES-1:0] vld_q;
  logic             vld_rd_q;
  logic [31:0]      ip_rd, ip_eff, key;
  logic [47:0]      mac_rd;
  logic             hit, last, wr_en;
  logic [31:0]      own_ip_q;
  logic [47:0]      own_mac_q;
  logic             out_valid_q;
  out_item_t        out_q, res;

  // Station addresses, held for the transmit side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_IP:  own_ip_q  <= cfg_data_i[31:0];
        CFG_OWN_MAC: own_mac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read address: slot zero on load, otherwise the slot after the current one (held at the last slot)
  always_comb begin
    if (cmd_i.load) begin
      rd_addr = '0;
    end else if (idx_q == LAST_IDX) begin
      rd_addr = idx_q;
    end else begin
      rd_addr = idx_q + IW'(1);
    end
  end

  // Slot compare: an invalid slot reads as an empty IP
  assign ip_eff = vld_rd_q ? ip_rd : '0;
  assign key    = item_q.operation ? item_q.query_ip : '0;
  assign hit    = (ip_eff == key);
  assign last   = (idx_q == LAST_IDX);
  assign wr_en  = cmd_i.scan && hit && !item_q.operation;

  arpc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ip_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (item_q.snd_ip_addr),
    .raddr_i (rd_addr),
    .rdata_o (ip_rd)
  );

  arpc_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (item_q.snd_hw_addr),
    .raddr_i (rd_addr),
    .rdata_o (mac_rd)
  );

  // Slot valid bits, cleared at reset so the IP store starts empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
      vld_rd_q <= vld_q[rd_addr];
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      idx_q  <= '0;
      hit_q  <= 1'b0;
      fmac_q <= '0;
    end else if (cmd_i.scan) begin
      if (hit) begin
        hit_q  <= 1'b1;
        fmac_q <= mac_rd;
      end else begin
        idx_q <= rd_addr;
      end
    end
  end

  // Result assembly
  always_comb begin
    res = '0;
    priority if (item_q.operation) begin
      if (hit_q) begin
        res.status    = ST_OK;
        res.found_mac = fmac_q;
      end else begin
        res.status         = ST_MISS;
        res.send_valid     = 1'b1;
        res.send_opcode    = SEND_OPC_REQUEST;
        res.send_dest_mac  = BCAST_MAC;
        res.send_target_ip = item_q.query_ip;
      end
    end else if (item_q.arp_opcode == OPC_REQUEST) begin
      res.status          = ST_OK;
      res.send_valid      = 1'b1;
      res.send_opcode     = SEND_OPC_REPLY;
      res.send_dest_mac   = item_q.frame_source_mac;
      res.send_target_mac = item_q.snd_hw_addr;
      res.send_target_ip  = item_q.snd_ip_addr;
    end else if (item_q.arp_opcode == OPC_REPLY) begin
      res.status = hit_q ? ST_OK : ST_FULL;
    end else begin
      res.status = ST_BADOP;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.needs_scan = in_data_i.operation || (in_data_i.arp_opcode == OPC_REPLY);
  assign stat_o.hit        = hit;
  assign stat_o.last       = last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== sv/arp_cache_responder.sv =====
// Top level of the ARP cache with reply engine.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A query or a received reply walks the slot table one slot per cycle, up to
// TABLE_ENTRIES slots, and stops at a hit or at the last slot.
// A received request or an unsupported opcode skips the walk.
// One request is in flight at a time; the next is taken once the result
// sits in the output register, which holds it while out_ready_i is low.
// Reset clears the slot valid bits at once; no clearing pass is needed.
module arp_cache_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arpc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output arpc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [47:0]         cfg_data_i
);
  import arpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // One request at a time: no new accept right after one
  a_single_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote a pending output");

  // Loaded result shows up on the output
  a_emit_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emitted result not presented");

  // Commands never overlap
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.emit}))
    else $error("overlapping datapath commands");

endmodule
